>>> hw/rtl/bdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// B-spline depth correction package
// Shared widths, codes and the knot weight function of the correction map.
// ----------------------------------------------------------------------------
package bdc_pkg;

   localparam int MAX_DEGREE = 3;
   localparam int TAP_W      = 2;
   localparam int CTRL_DEPTH = 1024;
   localparam int CTRL_AW    = $clog2(CTRL_DEPTH);

   localparam int NUM_W      = 18;
   localparam int DEN_W      = 14;
   localparam int QUOT_W     = 21;
   localparam int DIV_STEPS  = QUOT_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam int CSR_AW     = 5;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   typedef enum logic [2:0] {
      REG_DEGREE   = 3'd0,
      REG_SEG_X    = 3'd1,
      REG_SEG_Y    = 3'd2,
      REG_FRAME_W  = 3'd3,
      REG_FRAME_H  = 3'd4
   } reg_index_type;

   function automatic logic [16:0] knot_weight(input logic [TAP_W-1:0] sd,
                                               input logic [TAP_W-1:0] j,
                                               input logic [15:0] t);
      logic [17:0] v;
      logic [36:0] p;
      logic [16:0] w;
      v = {2'(sd - 2'd1 - j), 16'h0} + {2'b00, t};
      p = 37'(v) * 37'd349526;
      case (sd)
         2'd1: w = {1'b0, t};
         2'd2: w = v[17:1];
         2'd3: w = p[36:20];
         default: w = 17'd0;
      endcase
      return w;
   endfunction

endpackage

>>> hw/rtl/bdc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying control point writes and pixel evaluations.
// ----------------------------------------------------------------------------
interface bdc_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic [9:0]         point_index;
   logic signed [31:0] point_scale;
   logic signed [31:0] point_offset;
   logic [11:0]        pixel_x;
   logic [11:0]        pixel_y;

   modport source (output valid, cmd, point_index, point_scale, point_offset,
                   pixel_x, pixel_y, input ready);
   modport sink (input valid, cmd, point_index, point_scale, point_offset,
                 pixel_x, pixel_y, output ready);
endinterface

>>> hw/rtl/bdc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one depth correction per evaluated pixel.
// ----------------------------------------------------------------------------
interface bdc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] corr_scale;
   logic signed [31:0] corr_offset;
   logic               bad_position;

   modport source (output valid, corr_scale, corr_offset, bad_position,
                   input ready);
   modport sink (input valid, corr_scale, corr_offset, bad_position,
                 output ready);
endinterface

>>> hw/rtl/bdc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Position divider
// Restoring divider producing floor(num * 65536 / den), one bit a cycle.
// ----------------------------------------------------------------------------
module bdc_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [bdc_pkg::NUM_W-1:0]       num,
   input  logic [bdc_pkg::DEN_W-1:0]       den,
   output logic                            busy,
   output logic [bdc_pkg::QUOT_W-1:0]      quot
);

   logic                            run_ff, run_in;
   logic [bdc_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [bdc_pkg::DEN_W-1:0]       rem_ff, rem_in;
   logic [bdc_pkg::DEN_W-1:0]       den_ff, den_in;
   logic [bdc_pkg::QUOT_W-1:0]      sh_ff, sh_in;
   logic [bdc_pkg::DEN_W:0]         trial;
   logic                            ge;

   always_comb begin
      trial  = {rem_ff, sh_ff[bdc_pkg::QUOT_W-1]};
      ge     = trial >= {1'b0, den_ff};
      run_in = run_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      sh_in  = sh_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = bdc_pkg::DEN_W'(num[bdc_pkg::NUM_W-1:5]);
         den_in = den;
         sh_in  = {num[4:0], 16'h0};
      end else if (run_ff) begin
         rem_in = ge ? bdc_pkg::DEN_W'(trial - {1'b0, den_ff})
                     : trial[bdc_pkg::DEN_W-1:0];
         sh_in  = {sh_ff[bdc_pkg::QUOT_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == bdc_pkg::DIV_CNT_W'(bdc_pkg::DIV_STEPS - 1)) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      sh_ff  <= sh_in;
   end

   assign busy = run_ff;
   assign quot = sh_ff;

endmodule

>>> hw/rtl/bspline_depth_correction_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// B-spline depth correction map
// Evaluates a per-pixel scale and offset from a uniform B-spline control grid.
// ----------------------------------------------------------------------------
// A request beat with cmd low stores one control point.
// A request beat with cmd high evaluates one pixel and yields one response
// beat. Pixels outside the frame answer with bad_position set and zero
// results. Other pixels pass through the bit-serial position dividers,
// then one control point read a cycle and one blend a cycle through the
// scratch memory, with a drain between passes. One item is handled at a
// time; requests are taken only while the block is idle.
// The response sits in an output register, so a write beat or a new pixel
// may be accepted while the previous response waits; a finished pixel waits
// for the register to empty when the receiver stalls.
// Reset is synchronous and restores the registers to degree 0, one segment
// each way and a 640 by 480 frame. The control grid is not cleared; every
// entry must be written before a pixel reads it.
// ----------------------------------------------------------------------------
module bspline_depth_correction_map (
   input  logic                          clock,
   input  logic                          reset,
   bdc_req_if.sink                       req_if,
   bdc_rsp_if.source                     rsp_if,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bdc_pkg::CSR_AW-1:0]    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_DIV   = 7'b0000010,
      S_LOAD  = 7'b0000100,
      S_BLEND = 7'b0001000,
      S_DRAIN = 7'b0010000,
      S_FINAL = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   localparam int TW = bdc_pkg::TAP_W;
   localparam int AW = bdc_pkg::CTRL_AW;

   // Configuration registers.
   logic [1:0]  degree_ff;
   logic [4:0]  seg_x_ff, seg_y_ff;
   logic [12:0] frame_w_ff, frame_h_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff  <= 2'd0;
         seg_x_ff   <= 5'd1;
         seg_y_ff   <= 5'd1;
         frame_w_ff <= 13'd640;
         frame_h_ff <= 13'd480;
      end else if (csr_wr) begin
         case (csr_idx)
            bdc_pkg::REG_DEGREE:  degree_ff  <= pwdata[1:0];
            bdc_pkg::REG_SEG_X:   seg_x_ff   <= pwdata[4:0];
            bdc_pkg::REG_SEG_Y:   seg_y_ff   <= pwdata[4:0];
            bdc_pkg::REG_FRAME_W: frame_w_ff <= pwdata[12:0];
            bdc_pkg::REG_FRAME_H: frame_h_ff <= pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         bdc_pkg::REG_DEGREE:  prdata = {30'd0, degree_ff};
         bdc_pkg::REG_SEG_X:   prdata = {27'd0, seg_x_ff};
         bdc_pkg::REG_SEG_Y:   prdata = {27'd0, seg_y_ff};
         bdc_pkg::REG_FRAME_W: prdata = {19'd0, frame_w_ff};
         bdc_pkg::REG_FRAME_H: prdata = {19'd0, frame_h_ff};
         default:              prdata = 32'd0;
      endcase
   end

   // Control state.
   state_type       state_ff, state_in;
   logic            bad_ff, bad_in;
   logic [AW-1:0]   rb_ff, rb_in;
   logic [TW-1:0]   li_ff, li_in, lj_ff, lj_in;
   logic [TW-1:0]   sd_ff, sd_in;
   logic            pass_ff, pass_in;
   logic [TW-1:0]   o_ff, o_in, n_ff, n_in;
   logic            dr_ff, dr_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // Pipeline.
   logic            ld_valid_ff, ld_valid_in;
   logic [2*TW-1:0] ld_dest_ff, ld_dest_in;
   logic            s1_valid_ff, s1_valid_in;
   logic [2*TW-1:0] s1_dest_ff, s1_dest_in;
   logic [16:0]     s1_w1_ff, s1_w1_in;
   logic            s2_valid_ff;
   logic [2*TW-1:0] s2_dest_ff;
   logic signed [49:0] s2_ps1_ff, s2_ps0_ff, s2_po1_ff, s2_po0_ff;
   logic signed [49:0] ps1_in, ps0_in, po1_in, po0_in;

   // Memories.
   logic [63:0]     ctrl_mem [bdc_pkg::CTRL_DEPTH];
   logic [63:0]     ctrl_rdata_ff;
   logic [AW-1:0]   ctrl_raddr;
   logic [63:0]     tmp_mem [(bdc_pkg::MAX_DEGREE + 1) * (bdc_pkg::MAX_DEGREE + 1)];
   logic [63:0]     tmp_rdata_a_ff, tmp_rdata_b_ff;
   logic [2*TW-1:0] tmp_raddr_a, tmp_raddr_b;

   logic [63:0]     rsp_data_ff, rsp_data_in;
   logic            rsp_bad_ff, rsp_bad_in;

   // Dividers.
   logic                          div_start, div_busy, busy_x, busy_y;
   logic [bdc_pkg::QUOT_W-1:0]    quot_x, quot_y;
   logic [bdc_pkg::NUM_W-1:0]     num_x, num_y;

   logic        req_fire, eval_fire, pix_bad;
   logic [1:0]  deg;
   logic [5:0]  stride;
   logic [10:0] base;
   logic        slot_free;
   logic [15:0] frac;

   assign deg = (degree_ff > 2'(bdc_pkg::MAX_DEGREE)) ? 2'(bdc_pkg::MAX_DEGREE) : degree_ff;
   assign stride = {1'b0, seg_x_ff} + {4'd0, deg};
   assign base = 11'(quot_y[20:16]) * 11'(stride) + 11'(quot_x[20:16]);

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_fire  = req_if.valid && req_if.ready;
   assign pix_bad   = ({1'b0, req_if.pixel_x} >= frame_w_ff)
                   || ({1'b0, req_if.pixel_y} >= frame_h_ff);
   assign eval_fire = req_fire && (req_if.cmd == bdc_pkg::CMD_EVAL);
   assign div_start = eval_fire && !pix_bad;
   assign div_busy  = busy_x || busy_y;
   assign num_x = bdc_pkg::NUM_W'({req_if.pixel_x, 1'b1}) * bdc_pkg::NUM_W'(seg_x_ff);
   assign num_y = bdc_pkg::NUM_W'({req_if.pixel_y, 1'b1}) * bdc_pkg::NUM_W'(seg_y_ff);
   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign frac = pass_ff ? quot_y[15:0] : quot_x[15:0];

   bdc_div u_div_x (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_x),
      .den   ({frame_w_ff, 1'b0}),
      .busy  (busy_x),
      .quot  (quot_x)
   );

   bdc_div u_div_y (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_y),
      .den   ({frame_h_ff, 1'b0}),
      .busy  (busy_y),
      .quot  (quot_y)
   );

   always_comb begin
      state_in     = state_ff;
      bad_in       = bad_ff;
      rb_in        = rb_ff;
      li_in        = li_ff;
      lj_in        = lj_ff;
      sd_in        = sd_ff;
      pass_in      = pass_ff;
      o_in         = o_ff;
      n_in         = n_ff;
      dr_in        = dr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_bad_in   = rsp_bad_ff;
      ld_valid_in  = 1'b0;
      ld_dest_in   = {li_ff, lj_ff};
      s1_valid_in  = 1'b0;
      s1_dest_in   = '0;
      s1_w1_in     = bdc_pkg::knot_weight(sd_ff, o_ff, frac);
      ctrl_raddr   = rb_ff + AW'(lj_ff);
      tmp_raddr_a  = '0;
      tmp_raddr_b  = '0;

      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (pass_ff) begin
         tmp_raddr_a = {TW'(o_ff + 1'b1), n_ff};
         tmp_raddr_b = {o_ff, n_ff};
      end else begin
         tmp_raddr_a = {n_ff, TW'(o_ff + 1'b1)};
         tmp_raddr_b = {n_ff, o_ff};
      end
      s1_dest_in = tmp_raddr_b;

      case (state_ff)
         S_IDLE: begin
            if (eval_fire) begin
               bad_in   = pix_bad;
               state_in = pix_bad ? S_OUT : S_DIV;
            end
         end
         S_DIV: begin
            rb_in = base[AW-1:0];
            li_in = '0;
            lj_in = '0;
            if (!div_busy) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            ld_valid_in = 1'b1;
            lj_in = lj_ff + 1'b1;
            if (lj_ff == deg) begin
               lj_in = '0;
               li_in = li_ff + 1'b1;
               rb_in = rb_ff + AW'(stride);
               if (li_ff == deg) begin
                  sd_in    = deg;
                  pass_in  = 1'b0;
                  o_in     = '0;
                  n_in     = '0;
                  dr_in    = 1'b0;
                  state_in = S_DRAIN;
               end
            end
         end
         S_BLEND: begin
            s1_valid_in = 1'b1;
            n_in = n_ff + 1'b1;
            if (n_ff == sd_ff) begin
               n_in = '0;
               o_in = o_ff + 1'b1;
               if (o_ff == TW'(sd_ff - 1'b1)) begin
                  o_in     = '0;
                  dr_in    = 1'b0;
                  state_in = S_DRAIN;
                  pass_in  = !pass_ff;
                  if (pass_ff) begin
                     sd_in = sd_ff - 1'b1;
                  end
               end
            end
         end
         S_DRAIN: begin
            dr_in = 1'b1;
            if (dr_ff) begin
               state_in = (sd_ff == '0) ? S_FINAL : S_BLEND;
            end
         end
         S_FINAL: begin
            tmp_raddr_a = '0;
            state_in    = S_OUT;
         end
         S_OUT: begin
            tmp_raddr_a = '0;
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_bad_in   = bad_ff;
               rsp_data_in  = bad_ff ? 64'd0 : tmp_rdata_a_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Blend products.
   logic signed [31:0] a_s, a_o, b_s, b_o;
   logic [16:0]        s1_w0;

   assign a_s   = tmp_rdata_a_ff[63:32];
   assign a_o   = tmp_rdata_a_ff[31:0];
   assign b_s   = tmp_rdata_b_ff[63:32];
   assign b_o   = tmp_rdata_b_ff[31:0];
   assign s1_w0 = 17'd65536 - s1_w1_ff;

   assign ps1_in = $signed({1'b0, s1_w1_ff}) * a_s;
   assign ps0_in = $signed({1'b0, s1_w0}) * b_s;
   assign po1_in = $signed({1'b0, s1_w1_ff}) * a_o;
   assign po0_in = $signed({1'b0, s1_w0}) * b_o;

   function automatic logic signed [31:0] round_sat(input logic signed [50:0] s);
      logic signed [50:0] r;
      logic signed [31:0] q;
      r = (s + 51'sd32768) >>> 16;
      if (r > 51'sd2147483647) begin
         q = 32'sh7fffffff;
      end else if (r < -51'sd2147483648) begin
         q = 32'sh80000000;
      end else begin
         q = r[31:0];
      end
      return q;
   endfunction

   logic signed [31:0] res_s, res_o;

   assign res_s = round_sat(51'(s2_ps1_ff) + 51'(s2_ps0_ff));
   assign res_o = round_sat(51'(s2_po1_ff) + 51'(s2_po0_ff));

   always_ff @(posedge clock) begin
      if (req_fire && (req_if.cmd == bdc_pkg::CMD_WRITE)) begin
         ctrl_mem[req_if.point_index[AW-1:0]] <= {req_if.point_scale, req_if.point_offset};
      end
      ctrl_rdata_ff <= ctrl_mem[ctrl_raddr];
   end

   always_ff @(posedge clock) begin
      if (ld_valid_ff) begin
         tmp_mem[ld_dest_ff] <= ctrl_rdata_ff;
      end else if (s2_valid_ff) begin
         tmp_mem[s2_dest_ff] <= {res_s, res_o};
      end
      tmp_rdata_a_ff <= tmp_mem[tmp_raddr_a];
      tmp_rdata_b_ff <= tmp_mem[tmp_raddr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ld_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         li_ff        <= '0;
         lj_ff        <= '0;
         sd_ff        <= '0;
         pass_ff      <= 1'b0;
         o_ff         <= '0;
         n_ff         <= '0;
         dr_ff        <= 1'b0;
         bad_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ld_valid_ff  <= ld_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         li_ff        <= li_in;
         lj_ff        <= lj_in;
         sd_ff        <= sd_in;
         pass_ff      <= pass_in;
         o_ff         <= o_in;
         n_ff         <= n_in;
         dr_ff        <= dr_in;
         bad_ff       <= bad_in;
      end
      rb_ff       <= rb_in;
      ld_dest_ff  <= ld_dest_in;
      s1_dest_ff  <= s1_dest_in;
      s1_w1_ff    <= s1_w1_in;
      s2_dest_ff  <= s1_dest_ff;
      s2_ps1_ff   <= ps1_in;
      s2_ps0_ff   <= ps0_in;
      s2_po1_ff   <= po1_in;
      s2_po0_ff   <= po0_in;
      rsp_data_ff <= rsp_data_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.corr_scale   = rsp_data_ff[63:32];
   assign rsp_if.corr_offset  = rsp_data_ff[31:0];
   assign rsp_if.bad_position = rsp_bad_ff;

   a_pipe_empty_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!s2_valid_ff && !s1_valid_ff && !ld_valid_ff))
      else $error("blend pipeline busy while idle");

   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(ld_valid_ff && s2_valid_ff))
      else $error("load and blend write the scratch memory together");

   a_div_to_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && !div_busy) |=> (state_ff == S_LOAD))
      else $error("divider finished without starting the grid load");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_data_ff == 64'd0))
      else $error("out-of-frame response carries a non-zero value");

endmodule

>>> tb/bspline_depth_correction_map_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// B-spline depth correction map testbench
// Writes control points and evaluates pixels under several register settings,
// predicts every correction in Q16.16 and checks each response beat against
// it. Both channels idle and stall at random except in the calm phases.
// ----------------------------------------------------------------------------
module bspline_depth_correction_map_tb;

   typedef struct {
      logic               cmd;
      logic [9:0]         point_index;
      logic signed [31:0] point_scale;
      logic signed [31:0] point_offset;
      logic [11:0]        pixel_x;
      logic [11:0]        pixel_y;
   } request_type;

   typedef struct {
      logic signed [31:0] corr_scale;
      logic signed [31:0] corr_offset;
      logic               bad_position;
   } correction_type;

   class depth_corr_scoreboard;
      logic [1:0]         degree;
      logic [4:0]         seg_x;
      logic [4:0]         seg_y;
      logic [12:0]        frame_w;
      logic [12:0]        frame_h;
      logic signed [31:0] grid_scale [bdc_pkg::CTRL_DEPTH];
      logic signed [31:0] grid_offset [bdc_pkg::CTRL_DEPTH];
      bit                 written [bdc_pkg::CTRL_DEPTH];
      correction_type     pending_corr [$];
      int                 tap_list [16];
      int                 errors;

      function new();
         degree = 2'd0;
         seg_x = 5'd1;
         seg_y = 5'd1;
         frame_w = 13'd640;
         frame_h = 13'd480;
         errors = 0;
      endfunction

      function void set_reg(bdc_pkg::reg_index_type idx, logic [31:0] value);
         case (idx)
            bdc_pkg::REG_DEGREE: degree = value[1:0];
            bdc_pkg::REG_SEG_X: seg_x = value[4:0];
            bdc_pkg::REG_SEG_Y: seg_y = value[4:0];
            bdc_pkg::REG_FRAME_W: frame_w = value[12:0];
            bdc_pkg::REG_FRAME_H: frame_h = value[12:0];
            default: ;
         endcase
      endfunction

      function void map_position(int p, int seg, int size, output int idx,
                                 output longint frac);
         longint q;
         q = ((2 * longint'(p) + 1) * seg * 65536) / (2 * longint'(size));
         idx = int'(q >> 16);
         frac = q & 64'hFFFF;
      endfunction

      function longint knot_w(int sd, int j, longint t);
         return ((sd - 1 - j) * 64'sd65536 + t) / sd;
      endfunction

      function logic signed [31:0] mix(longint w1, longint a, longint w0, longint b);
         longint s;
         s = (w1 * a + w0 * b + 32768) >>> 16;
         if (s > 64'sd2147483647) s = 64'sd2147483647;
         if (s < -64'sd2147483648) s = -64'sd2147483648;
         return s[31:0];
      endfunction

      function bit inside_frame(int x, int y);
         return x < frame_w && y < frame_h;
      endfunction

      // Fills tap_list with the grid entries a pixel reads; returns how many.
      function int gather_taps(int x, int y);
         int i0, j0, n, stride;
         longint t;
         n = 0;
         stride = seg_x + degree;
         map_position(x, seg_x, frame_w, j0, t);
         map_position(y, seg_y, frame_h, i0, t);
         for (int i = 0; i <= degree; i++)
            for (int j = 0; j <= degree; j++) begin
               tap_list[n] = ((i0 + i) * stride + j0 + j) % bdc_pkg::CTRL_DEPTH;
               n++;
            end
         return n;
      endfunction

      function correction_type evaluate(int x, int y);
         correction_type c;
         logic signed [31:0] ts [4][4];
         logic signed [31:0] tof [4][4];
         int i0, j0, sd, stride, k;
         longint tx, ty, w1, w0;
         c.bad_position = 1'b0;
         stride = seg_x + degree;
         map_position(x, seg_x, frame_w, j0, tx);
         map_position(y, seg_y, frame_h, i0, ty);
         for (int i = 0; i <= degree; i++)
            for (int j = 0; j <= degree; j++) begin
               k = ((i0 + i) * stride + j0 + j) % bdc_pkg::CTRL_DEPTH;
               ts[i][j] = grid_scale[k];
               tof[i][j] = grid_offset[k];
            end
         for (int lvl = 0; lvl < degree; lvl++) begin
            sd = degree - lvl;
            for (int j = 0; j < sd; j++) begin
               w1 = knot_w(sd, j, tx);
               w0 = 65536 - w1;
               for (int i = 0; i <= sd; i++) begin
                  ts[i][j] = mix(w1, ts[i][j + 1], w0, ts[i][j]);
                  tof[i][j] = mix(w1, tof[i][j + 1], w0, tof[i][j]);
               end
            end
            for (int i = 0; i < sd; i++) begin
               w1 = knot_w(sd, i, ty);
               w0 = 65536 - w1;
               for (int j = 0; j <= sd; j++) begin
                  ts[i][j] = mix(w1, ts[i + 1][j], w0, ts[i][j]);
                  tof[i][j] = mix(w1, tof[i + 1][j], w0, tof[i][j]);
               end
            end
         end
         c.corr_scale = ts[0][0];
         c.corr_offset = tof[0][0];
         return c;
      endfunction

      function void note_request(request_type r);
         correction_type c;
         if (r.cmd == bdc_pkg::CMD_WRITE) begin
            grid_scale[r.point_index] = r.point_scale;
            grid_offset[r.point_index] = r.point_offset;
            written[r.point_index] = 1'b1;
         end else begin
            if (!inside_frame(r.pixel_x, r.pixel_y)) begin
               c.corr_scale = 0;
               c.corr_offset = 0;
               c.bad_position = 1'b1;
            end else begin
               c = evaluate(r.pixel_x, r.pixel_y);
            end
            pending_corr.push_back(c);
         end
      endfunction

      function void check_response(correction_type got);
         correction_type exp_c;
         if (pending_corr.size() == 0) begin
            $display("%0t: response beat with nothing expected: scale %h offset %h bad %b",
                     $realtime, got.corr_scale, got.corr_offset, got.bad_position);
            errors++;
            return;
         end
         exp_c = pending_corr.pop_front();
         if (got.corr_scale !== exp_c.corr_scale) begin
            $display("%0t: corr_scale expected %h actual %h", $realtime,
                     exp_c.corr_scale, got.corr_scale);
            errors++;
         end
         if (got.corr_offset !== exp_c.corr_offset) begin
            $display("%0t: corr_offset expected %h actual %h", $realtime,
                     exp_c.corr_offset, got.corr_offset);
            errors++;
         end
         if (got.bad_position !== exp_c.bad_position) begin
            $display("%0t: bad_position expected %b actual %b", $realtime,
                     exp_c.bad_position, got.bad_position);
            errors++;
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       psel;
   logic                       penable;
   logic                       pwrite;
   logic [bdc_pkg::CSR_AW-1:0] paddr;
   logic [31:0]                pwdata;
   logic [31:0]                prdata;
   logic                       pready;
   bit                         calm;
   int                         rsp_hold = 0;

   bdc_req_if req_if ();
   bdc_rsp_if rsp_if ();

   depth_corr_scoreboard corr_board;

   bspline_depth_correction_map DUT (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 19);
      if (r < 14) return $urandom_range(1, 3);
      if (r < 19) return $urandom_range(4, 9);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (rsp_if.valid && rsp_if.ready)
         corr_board.check_response('{rsp_if.corr_scale, rsp_if.corr_offset,
                                     rsp_if.bad_position});
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_if.ready <= 1'b1;
         if (!calm && $urandom_range(0, 3) == 0) rsp_hold = gap_length();
      end
   end

   task automatic csr_write(bdc_pkg::reg_index_type idx, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= bdc_pkg::CSR_AW'(4 * int'(idx));
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      corr_board.set_reg(idx, value);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_beat(request_type r);
      req_if.valid <= 1'b1;
      req_if.cmd <= r.cmd;
      req_if.point_index <= r.point_index;
      req_if.point_scale <= r.point_scale;
      req_if.point_offset <= r.point_offset;
      req_if.pixel_x <= r.pixel_x;
      req_if.pixel_y <= r.pixel_y;
      do @(posedge clock); while (!req_if.ready);
      corr_board.note_request(r);
      if (!calm && $urandom_range(0, 2) == 0) begin
         req_if.valid <= 1'b0;
         repeat (gap_length()) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] point_value();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 32'h0003_0000);
         default: return $urandom;
      endcase
   endfunction

   task automatic write_point(int idx, logic [31:0] s, logic [31:0] o);
      request_type r;
      r.cmd = bdc_pkg::CMD_WRITE;
      r.point_index = idx[9:0];
      r.point_scale = s;
      r.point_offset = o;
      r.pixel_x = 12'($urandom);
      r.pixel_y = 12'($urandom);
      send_beat(r);
   endtask

   task automatic eval_pixel(int x, int y);
      request_type r;
      int n;
      if (corr_board.inside_frame(x, y)) begin
         n = corr_board.gather_taps(x, y);
         for (int k = 0; k < n; k++)
            if (!corr_board.written[corr_board.tap_list[k]])
               write_point(corr_board.tap_list[k], point_value(), point_value());
      end
      r.cmd = bdc_pkg::CMD_EVAL;
      r.point_index = 10'($urandom);
      r.point_scale = $urandom;
      r.point_offset = $urandom;
      r.pixel_x = x[11:0];
      r.pixel_y = y[11:0];
      send_beat(r);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (corr_board.pending_corr.size() != 0);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_phase(int deg, int sx, int sy, int fw, int fh);
      drain();
      csr_write(bdc_pkg::REG_DEGREE, deg);
      csr_write(bdc_pkg::REG_SEG_X, sx);
      csr_write(bdc_pkg::REG_SEG_Y, sy);
      csr_write(bdc_pkg::REG_FRAME_W, fw);
      csr_write(bdc_pkg::REG_FRAME_H, fh);
   endtask

   task automatic random_pixels(int count);
      int fw, fh;
      fw = corr_board.frame_w;
      fh = corr_board.frame_h;
      repeat (count) begin
         if ($urandom_range(0, 6) == 0)
            write_point($urandom_range(0, bdc_pkg::CTRL_DEPTH - 1), point_value(),
                        point_value());
         else if ($urandom_range(0, 9) == 0 || fw == 0 || fh == 0)
            eval_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
         else
            eval_pixel($urandom_range(0, fw - 1), $urandom_range(0, fh - 1));
      end
   endtask

   initial begin
      #40_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      corr_board = new();
      calm = 1'b0;
      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req_if.valid <= 1'b0;
      req_if.cmd <= bdc_pkg::CMD_WRITE;
      req_if.point_index <= '0;
      req_if.point_scale <= '0;
      req_if.point_offset <= '0;
      req_if.pixel_x <= '0;
      req_if.pixel_y <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      set_phase(3, 2, 2, 640, 480);
      write_point(0, 32'h7FFF_FFFF, 32'h8000_0000);
      write_point(bdc_pkg::CTRL_DEPTH - 1, 32'h8000_0000, 32'h7FFF_FFFF);
      eval_pixel(0, 0);
      eval_pixel(639, 479);
      eval_pixel(320, 240);
      eval_pixel(640, 0);
      eval_pixel(0, 480);
      eval_pixel(4095, 4095);
      set_phase(0, 1, 1, 1, 1);
      eval_pixel(0, 0);
      eval_pixel(1, 0);
      eval_pixel(0, 1);
      set_phase(3, 29, 29, 4096, 4096);
      eval_pixel(0, 0);
      eval_pixel(4095, 4095);
      eval_pixel(2048, 17);

      for (int p = 0; p < 12; p++) begin
         calm = (p % 4 == 3);
         case (p)
            0: set_phase(3, 29, 29, 4096, 4096);
            1: set_phase(2, 1, 29, 1, 4096);
            2: set_phase(1, 31, 0, 640, 480);
            3: set_phase(0, 1, 1, 4096, 1);
            default:
               set_phase(p % 4, $urandom_range(1, 29), $urandom_range(1, 29),
                         $urandom_range(1, 4096), $urandom_range(1, 4096));
         endcase
         random_pixels(p < 4 ? 40 : 90);
         if (p == 6) drain();
      end
      calm = 1'b0;

      drain();
      if (corr_board.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
